@@ sv/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int unsigned FRAC_BITS_DEFAULT = 8;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT  = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic        is_mul;
      logic        is_div;
      logic        div_neg;
      logic        div_zero;
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  status;
   } side_type;

   typedef struct packed {
      logic [31:0] word;
      logic        sat;
   } clamp_type;

   function automatic clamp_type clamp_mag(input logic neg, input logic [63:0] mag);
      clamp_type   r;
      logic [31:0] m;
      r.sat = 1'b0;
      m     = mag[31:0];
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            r.sat = 1'b1;
            m     = 32'h8000_0000;
         end
         r.word = 32'd0 - m;
      end else begin
         if (mag > 64'h7FFF_FFFF) begin
            r.sat = 1'b1;
            m     = 32'h7FFF_FFFF;
         end
         r.word = m;
      end
      return r;
   endfunction

endpackage

@@ sv/fpa_req_if.sv @@
// ----------------------------------------------------------------------------
// fpa_req_if
// Request channel: operation code and two raw operands.
// ----------------------------------------------------------------------------
interface fpa_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         req_type;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, output req_type, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input req_type, input operand_a, input operand_b,
                   output ready);
endinterface

@@ sv/fpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fpa_rsp_if
// Response channel: raw result, compare flag and status.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_raw;
   logic               compare_true;
   logic [1:0]         status;

   modport source (output valid, output result_raw, output compare_true, output status,
                   input ready);
   modport sink   (input valid, input result_raw, input compare_true, input status,
                   output ready);
endinterface

@@ sv/fpa_mul.sv @@
// ----------------------------------------------------------------------------
// fpa_mul
// Registered signed product with round-half-away and saturation on the output.
// ----------------------------------------------------------------------------
module fpa_mul #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic [31:0]        mul_res,
   output logic               mul_sat
);
   import fpa_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic [63:0]        mag;
   logic [63:0]        rounded;
   clamp_type          cl;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      mag     = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      rounded = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      cl      = clamp_mag(prod_ff[63], rounded);
      mul_res = cl.word;
      mul_sat = cl.sat;
   end

endmodule

@@ sv/fpa_div_step.sv @@
// ----------------------------------------------------------------------------
// fpa_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step #(
   parameter int unsigned NUM_BITS = 41
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [31:0]             in_rem,
   input  logic [NUM_BITS-1:0]     in_num,
   input  logic [NUM_BITS-1:0]     in_quo,
   input  logic [31:0]             in_den,
   input  fpa_pkg::side_type       in_side,
   output logic                    out_valid,
   output logic [31:0]             out_rem,
   output logic [NUM_BITS-1:0]     out_num,
   output logic [NUM_BITS-1:0]     out_quo,
   output logic [31:0]             out_den,
   output fpa_pkg::side_type       out_side
);
   import fpa_pkg::*;

   logic                valid_ff;
   logic [31:0]         rem_ff, rem_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [31:0]         den_ff;
   side_type            side_ff;
   logic [32:0]         rem_sh;
   logic [33:0]         trial;
   logic                fits;

   always_comb begin
      rem_sh = {in_rem, in_num[NUM_BITS-1]};
      trial  = {1'b0, rem_sh} - {2'b00, in_den};
      fits   = ~trial[33];
      rem_in = fits ? trial[31:0] : rem_sh[31:0];
      quo_in = {in_quo[NUM_BITS-2:0], fits};
      num_in = in_num << 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

@@ sv/fixed_point_alu_q24_8_top.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_top
// Pipelined signed fixed-point ALU, Q(32-F).F, saturating, exact rounding.
//
//   channel | dir | payload
//   req_ch  | in  | req_type, operand_a, operand_b
//   rsp_ch  | out | result_raw, compare_true, status
//
// One request per cycle while the output is not stalled; a response passes
// through FRAC_BITS + 36 register stages after its request transfers, set by the
// restoring divider, one quotient bit per stage over FRAC_BITS + 33 bits.
// All operations run down the same pipeline, so responses keep request order.
// Reset is synchronous and clears only the stage valid bits.
// A stall at the output holds every stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_top #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fpa_req_if.sink     req_ch,
   fpa_rsp_if.source   rsp_ch
);
   import fpa_pkg::*;

   localparam int unsigned NUM_BITS = FRAC_BITS + 33;

   logic               advance;
   logic               v1_ff;
   op_type             op1_ff;
   logic signed [31:0] a1_ff, b1_ff;
   logic               v2_ff;
   side_type           side2_ff, side2_in;
   logic [31:0]        den2_ff, den2_in;
   logic [NUM_BITS-1:0] num2_ff, num2_in;
   logic [31:0]        mul_res;
   logic               mul_sat;
   side_type           side_m;
   logic [32:0]        sum33;
   logic [31:0]        abs_a;

   logic                valid_c [0:NUM_BITS];
   logic [31:0]         rem_c   [0:NUM_BITS];
   logic [NUM_BITS-1:0] num_c   [0:NUM_BITS];
   logic [NUM_BITS-1:0] quo_c   [0:NUM_BITS];
   logic [31:0]         den_c   [0:NUM_BITS];
   side_type            side_c  [0:NUM_BITS];

   logic               out_valid_ff;
   logic [31:0]        out_res_ff, out_res_in;
   logic               out_cmp_ff, out_cmp_in;
   logic [1:0]         out_st_ff, out_st_in;
   logic [NUM_BITS-1:0] q_round;
   clamp_type          div_cl;

   assign advance      = ~out_valid_ff | rsp_ch.ready;
   assign req_ch.ready = advance;

   // stage 1: capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff <= op_type'(req_ch.req_type);
         a1_ff  <= req_ch.operand_a;
         b1_ff  <= req_ch.operand_b;
      end
   end

   // stage 2: short operations, divider setup, product
   always_comb begin
      side2_in          = '0;
      side2_in.status   = ST_OK;
      abs_a             = a1_ff[31] ? (32'd0 - a1_ff) : a1_ff;
      den2_in           = b1_ff[31] ? (32'd0 - b1_ff) : b1_ff;
      num2_in           = {abs_a, {(FRAC_BITS + 1){1'b0}}};
      side2_in.div_neg  = a1_ff[31] ^ b1_ff[31];
      side2_in.div_zero = (b1_ff == 32'sd0);
      sum33             = '0;
      unique case (op1_ff) inside
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            if (op1_ff == OP_ADD) begin
               sum33 = {a1_ff[31], a1_ff} + {b1_ff[31], b1_ff};
            end else if (op1_ff == OP_SUB) begin
               sum33 = {a1_ff[31], a1_ff} - {b1_ff[31], b1_ff};
            end else if (op1_ff == OP_INC) begin
               sum33 = {a1_ff[31], a1_ff} + 33'd1;
            end else begin
               sum33 = {a1_ff[31], a1_ff} - 33'd1;
            end
            if (sum33[32] != sum33[31]) begin
               side2_in.res    = sum33[32] ? WORD_MIN : WORD_MAX;
               side2_in.status = ST_SAT;
            end else begin
               side2_in.res = sum33[31:0];
            end
         end
         OP_MUL: side2_in.is_mul = 1'b1;
         OP_DIV: side2_in.is_div = 1'b1;
         OP_GT:  side2_in.cmp = (a1_ff > b1_ff);
         OP_LT:  side2_in.cmp = (a1_ff < b1_ff);
         OP_GE:  side2_in.cmp = (a1_ff >= b1_ff);
         OP_LE:  side2_in.cmp = (a1_ff <= b1_ff);
         OP_EQ:  side2_in.cmp = (a1_ff == b1_ff);
         OP_NE:  side2_in.cmp = (a1_ff != b1_ff);
         OP_MIN: side2_in.res = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         OP_MAX: side2_in.res = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         OP_FROM_INT: begin
            if ((&a1_ff[31:31-FRAC_BITS]) || ~(|a1_ff[31:31-FRAC_BITS])) begin
               side2_in.res = a1_ff <<< FRAC_BITS;
            end else begin
               side2_in.res    = a1_ff[31] ? WORD_MIN : WORD_MAX;
               side2_in.status = ST_SAT;
            end
         end
         OP_TO_INT: side2_in.res = a1_ff >>> FRAC_BITS;
         default:   side2_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side2_ff <= side2_in;
         den2_ff  <= den2_in;
         num2_ff  <= num2_in;
      end
   end

   fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .advance (advance),
      .a       (a1_ff),
      .b       (b1_ff),
      .mul_res (mul_res),
      .mul_sat (mul_sat)
   );

   always_comb begin
      side_m = side2_ff;
      if (side2_ff.is_mul) begin
         side_m.res    = mul_res;
         side_m.status = mul_sat ? ST_SAT : ST_OK;
      end
   end

   // divider chain
   assign valid_c[0] = v2_ff;
   assign rem_c[0]   = '0;
   assign num_c[0]   = num2_ff;
   assign quo_c[0]   = '0;
   assign den_c[0]   = den2_ff;
   assign side_c[0]  = side_m;

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_div
      fpa_div_step #(.NUM_BITS(NUM_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_c[k]),
         .in_rem    (rem_c[k]),
         .in_num    (num_c[k]),
         .in_quo    (quo_c[k]),
         .in_den    (den_c[k]),
         .in_side   (side_c[k]),
         .out_valid (valid_c[k+1]),
         .out_rem   (rem_c[k+1]),
         .out_num   (num_c[k+1]),
         .out_quo   (quo_c[k+1]),
         .out_den   (den_c[k+1]),
         .out_side  (side_c[k+1])
      );
   end

   // output stage: finish division rounding, select result
   always_comb begin
      q_round    = (quo_c[NUM_BITS] + NUM_BITS'(1)) >> 1;
      div_cl     = clamp_mag(side_c[NUM_BITS].div_neg, 64'(q_round));
      out_res_in = side_c[NUM_BITS].res;
      out_cmp_in = side_c[NUM_BITS].cmp;
      out_st_in  = side_c[NUM_BITS].status;
      if (side_c[NUM_BITS].is_div) begin
         if (side_c[NUM_BITS].div_zero) begin
            out_res_in = '0;
            out_st_in  = ST_DIV0;
         end else begin
            out_res_in = div_cl.word;
            out_st_in  = div_cl.sat ? ST_SAT : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_c[NUM_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= out_res_in;
         out_cmp_ff <= out_cmp_in;
         out_st_ff  <= out_st_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_raw   = out_res_ff;
   assign rsp_ch.compare_true = out_cmp_ff;
   assign rsp_ch.status       = out_st_ff;

`ifndef NO_ASSERTIONS
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_DIV0) |-> rsp_ch.result_raw == 32'sd0)
      else $error("divide by zero response carries nonzero result");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.compare_true) |->
         (rsp_ch.result_raw == 32'sd0 && rsp_ch.status == ST_OK))
      else $error("true comparison with nonzero result or status");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request side stalled without output backpressure");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(rsp_ch.result_raw)))
      else $error("stalled response changed");
`endif

endmodule
